### design/ack_retransmit_tracker_assert.svh
// Assertion macros for the acknowledgement retransmit tracker.
// Included by ack_retransmit_tracker; it needs nothing else.
`ifndef ACK_RETRANSMIT_TRACKER_ASSERT_SVH
`define ACK_RETRANSMIT_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ART_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ART_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/art_pkg.sv
// Package for the acknowledgement retransmit tracker: item types, codes and sizes.
// Used by ack_retransmit_tracker; depends on nothing.
`default_nettype none

package art_pkg;

  // Default number of table slots.
  localparam int SLOTS_DEF = 8;

  localparam int KEY_W    = 32;
  localparam int KIND_W   = 8;
  localparam int TIME_W   = 32;
  localparam int TMO_W    = 16;
  localparam int RETRY_W  = 4;
  localparam int SLOT_W   = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  // Operation codes.
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_CHECK  = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NO_FREE   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY   = 1'd1;

  // Register reset values.
  localparam logic [TMO_W-1:0]   TIMEOUT_RST = 16'd5;
  localparam logic [RETRY_W-1:0] RETRY_RST   = 4'd3;
  localparam logic [RETRY_W-1:0] RETRY_MAX   = 4'd15;

  typedef struct packed {
    logic [1:0]        operation;
    logic [KEY_W-1:0]  message_key;
    logic [KIND_W-1:0] message_kind;
    logic [TIME_W-1:0] current_time;
  } art_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot_used;
    logic              retransmit_needed;
    logic              disconnect;
    logic              timeout_latched;
  } art_out_t;

endpackage

`default_nettype wire

### design/ack_retransmit_tracker.sv
// Acknowledgement retransmit tracker: a slot table of outstanding messages with timeouts.
// Depends on art_pkg and on the assertion macros in ack_retransmit_tracker_assert.svh.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------
//   in      | input     | in_valid / in_stall  | art_pkg::art_in_t
//   out     | output    | out_valid / out_stall| art_pkg::art_out_t
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_wdata
//
// One item scans the table one slot per cycle through a single compare and
// subtract unit, ending early on a hit for add and remove, or on a disconnect
// for check. An add with no hit then claims a free slot if any; unknown codes skip it.
// Reset is synchronous and clears the valid bits and the sticky disconnect flag.
// The next item is taken while a finished result waits in the output register.
`default_nettype none

`include "ack_retransmit_tracker_assert.svh"

module ack_retransmit_tracker #(
  parameter int SLOTS = art_pkg::SLOTS_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  art_pkg::art_in_t             in_data,
  output logic                               out_valid,
  input  wire                                out_stall,
  output art_pkg::art_out_t                  out_data,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [art_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [art_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import art_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  // Sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_CLAIM = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic [IW-1:0]       free_idx_r, free_idx_nxt;
  logic                free_found_r, free_found_nxt;
  art_in_t             req_r, req_nxt;
  logic [1:0]          status_r, status_nxt;
  logic [IW-1:0]       slot_r, slot_nxt;
  logic                resend_r, resend_nxt;
  logic                drop_r, drop_nxt;
  logic                lost_r, lost_nxt;
  logic [SLOTS-1:0]    valid_r, valid_nxt;
  logic [TMO_W-1:0]    timeout_r, timeout_nxt;
  logic [RETRY_W-1:0]  retry_lim_r, retry_lim_nxt;
  logic                out_valid_r, out_valid_nxt;
  art_out_t            out_data_r, out_data_nxt;

  // Slot storage, read one slot per cycle.
  logic [KEY_W-1:0]    key_mem   [SLOTS];
  logic [KIND_W-1:0]   kind_mem  [SLOTS];
  logic [TIME_W-1:0]   sent_mem  [SLOTS];
  logic [RETRY_W-1:0]  retry_mem [SLOTS];
  logic [KEY_W-1:0]    rd_key_r;
  logic [KIND_W-1:0]   rd_kind_r;
  logic [TIME_W-1:0]   rd_sent_r;
  logic [RETRY_W-1:0]  rd_retry_r;

  logic                wr_key_en, wr_kind_en, wr_sent_en, wr_retry_en;
  logic [IW-1:0]       wr_addr;
  logic [RETRY_W-1:0]  wr_retry_data;

  // Shared compare and subtract unit on the slot under scan.
  logic                slot_valid;
  logic                key_eq;
  logic                kind_eq;
  logic [TIME_W-1:0]   elapsed;
  logic                timed_out;
  logic [RETRY_W-1:0]  retry_inc;
  logic                scan_last;
  logic                in_accept;

  assign in_accept  = in_valid && !in_stall;
  assign in_stall   = (state_r != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  assign slot_valid = valid_r[idx_r];
  assign key_eq     = (rd_key_r == req_r.message_key);
  assign kind_eq    = (rd_kind_r == req_r.message_kind);
  assign elapsed    = req_r.current_time - rd_sent_r;
  assign timed_out  = (elapsed >= {{(TIME_W-TMO_W){1'b0}}, timeout_r});
  assign retry_inc  = (rd_retry_r == RETRY_MAX) ? RETRY_MAX : rd_retry_r + 1'b1;
  assign scan_last  = (idx_r == LAST_IDX);

  // Sequencer and result bookkeeping.
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = '0;
    free_idx_nxt   = free_idx_r;
    free_found_nxt = free_found_r;
    req_nxt        = req_r;
    status_nxt     = status_r;
    slot_nxt       = slot_r;
    resend_nxt     = resend_r;
    drop_nxt       = drop_r;
    lost_nxt       = lost_r;
    valid_nxt      = valid_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    wr_key_en      = 1'b0;
    wr_kind_en     = 1'b0;
    wr_sent_en     = 1'b0;
    wr_retry_en    = 1'b0;
    wr_addr        = idx_r;
    wr_retry_data  = retry_inc;

    // The output register drains independently of the sequencer.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          req_nxt        = in_data;
          status_nxt     = ST_DONE;
          slot_nxt       = '0;
          resend_nxt     = 1'b0;
          drop_nxt       = 1'b0;
          free_found_nxt = 1'b0;
          free_idx_nxt   = '0;
          if (in_data.operation == OP_ADD || in_data.operation == OP_REMOVE ||
              in_data.operation == OP_CHECK) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end

      S_SCAN: begin
        idx_nxt = idx_r + 1'b1;
        case (req_r.operation)
          OP_ADD: begin
            if (slot_valid && key_eq && kind_eq) begin
              // Refresh the matching entry and stop.
              wr_sent_en = 1'b1;
              slot_nxt   = idx_r;
              state_nxt  = S_FIN;
            end else begin
              if (!slot_valid && !free_found_r) begin
                free_found_nxt = 1'b1;
                free_idx_nxt   = idx_r;
              end
              if (scan_last) begin
                if (free_found_nxt) begin
                  state_nxt = S_CLAIM;
                end else begin
                  status_nxt = ST_NO_FREE;
                  state_nxt  = S_FIN;
                end
              end
            end
          end
          OP_REMOVE: begin
            if (slot_valid && key_eq) begin
              valid_nxt[idx_r] = 1'b0;
              slot_nxt         = idx_r;
              state_nxt        = S_FIN;
            end else if (scan_last) begin
              status_nxt = ST_NOT_FOUND;
              state_nxt  = S_FIN;
            end
          end
          default: begin
            // Timeout check: bump the retry count, then resend or disconnect.
            if (slot_valid && timed_out) begin
              wr_retry_en = 1'b1;
              if (retry_inc >= retry_lim_r) begin
                lost_nxt   = 1'b1;
                drop_nxt   = 1'b1;
                resend_nxt = 1'b0;
                state_nxt  = S_FIN;
              end else begin
                wr_sent_en = 1'b1;
                resend_nxt = 1'b1;
                if (scan_last) begin
                  state_nxt = S_FIN;
                end
              end
            end else if (scan_last) begin
              state_nxt = S_FIN;
            end
          end
        endcase
        if (state_nxt != S_SCAN) begin
          idx_nxt = '0;
        end
      end

      S_CLAIM: begin
        // Write the new entry into the first free slot.
        wr_addr                = free_idx_r;
        wr_key_en              = 1'b1;
        wr_kind_en             = 1'b1;
        wr_sent_en             = 1'b1;
        wr_retry_en            = 1'b1;
        wr_retry_data          = '0;
        valid_nxt[free_idx_r]  = 1'b1;
        slot_nxt               = free_idx_r;
        state_nxt              = S_FIN;
      end

      default: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt                  = 1'b1;
          out_data_nxt.status            = status_r;
          out_data_nxt.slot_used         = SLOT_W'(slot_r);
          out_data_nxt.retransmit_needed = resend_r;
          out_data_nxt.disconnect        = drop_r;
          out_data_nxt.timeout_latched   = lost_r;
          state_nxt                      = S_IDLE;
        end
      end
    endcase
  end

  // Configuration registers.
  always_comb begin
    timeout_nxt   = timeout_r;
    retry_lim_nxt = retry_lim_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TIMEOUT: timeout_nxt   = cfg_wdata[TMO_W-1:0];
        default:     retry_lim_nxt = cfg_wdata[RETRY_W-1:0];
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      idx_r        <= '0;
      free_found_r <= 1'b0;
      lost_r       <= 1'b0;
      valid_r      <= '0;
      timeout_r    <= TIMEOUT_RST;
      retry_lim_r  <= RETRY_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      free_found_r <= free_found_nxt;
      lost_r       <= lost_nxt;
      valid_r      <= valid_nxt;
      timeout_r    <= timeout_nxt;
      retry_lim_r  <= retry_lim_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    free_idx_r <= free_idx_nxt;
    req_r      <= req_nxt;
    status_r   <= status_nxt;
    slot_r     <= slot_nxt;
    resend_r   <= resend_nxt;
    drop_r     <= drop_nxt;
    out_data_r <= out_data_nxt;
  end

  // Slot memories: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_key_en) begin
      key_mem[wr_addr] <= req_r.message_key;
    end
    if (wr_kind_en) begin
      kind_mem[wr_addr] <= req_r.message_kind;
    end
    if (wr_sent_en) begin
      sent_mem[wr_addr] <= req_r.current_time;
    end
    if (wr_retry_en) begin
      retry_mem[wr_addr] <= wr_retry_data;
    end
    rd_key_r   <= key_mem[idx_nxt];
    rd_kind_r  <= kind_mem[idx_nxt];
    rd_sent_r  <= sent_mem[idx_nxt];
    rd_retry_r <= retry_mem[idx_nxt];
  end

  // Checks on the sequencer and the result flags.
  `ART_ASSERT_NEXT(a_lost_sticky, clk, rst_n, lost_r, lost_r, "disconnect flag cleared")
  `ART_ASSERT_NOW(a_drop_flags, clk, rst_n, out_valid_r && out_data_r.disconnect,
                  out_data_r.timeout_latched && !out_data_r.retransmit_needed,
                  "disconnect without latched flag or with retransmit")
  `ART_ASSERT_NOW(a_latched_match, clk, rst_n, out_valid_r && out_data_r.timeout_latched,
                  lost_r, "latched flag in result but not in state")
  `ART_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_accept, in_stall,
                   "item taken while another is in progress")

endmodule

`default_nettype wire

### tb/art_tracker_checker.sv
// Checker for the acknowledgement retransmit tracker: predicts each result and compares it.
// Watches the in, out and cfg channels of ack_retransmit_tracker; depends on art_pkg.
module art_tracker_checker #(
  parameter int SLOTS = art_pkg::SLOTS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  input  wire                              in_stall,
  input  art_pkg::art_in_t                 in_data,
  input  wire                              out_valid,
  input  wire                              out_stall,
  input  art_pkg::art_out_t                out_data,
  input  wire                              cfg_valid,
  input  wire                              cfg_ready,
  input  wire  [art_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [art_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output int                               mismatches,
  output int                               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import art_pkg::*;

  // Shadow copy of the table, the sticky flag and the two registers.
  logic                 slot_valid   [SLOTS];
  logic [KEY_W-1:0]     slot_key     [SLOTS];
  logic [KIND_W-1:0]    slot_kind    [SLOTS];
  logic [TIME_W-1:0]    slot_sent    [SLOTS];
  logic [RETRY_W-1:0]   slot_retries [SLOTS];
  logic                 link_lost;
  logic [TMO_W-1:0]     timeout_reg;
  logic [RETRY_W-1:0]   retry_reg;

  art_out_t expected_results[$];
  int       result_count;

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("[%0t] result %0d: %s expected %0d, got %0d", $realtime, result_count, what,
             want, got);
    mismatches++;
  endtask

  // Applies one item to the shadow table and returns the result it should produce.
  function automatic art_out_t predict_tracker_step(input art_in_t item);
    art_out_t          res;
    logic [TIME_W-1:0] elapsed;
    bit                done;
    res  = '0;
    done = 0;
    case (item.operation)
      OP_ADD: begin
        // A matching key and kind is refreshed before any free slot is claimed.
        for (int i = 0; i < SLOTS && !done; i++) begin
          if (slot_valid[i] && slot_key[i] == item.message_key &&
              slot_kind[i] == item.message_kind) begin
            slot_sent[i]  = item.current_time;
            res.slot_used = SLOT_W'(i);
            done          = 1;
          end
        end
        for (int i = 0; i < SLOTS && !done; i++) begin
          if (!slot_valid[i]) begin
            slot_valid[i]   = 1'b1;
            slot_key[i]     = item.message_key;
            slot_kind[i]    = item.message_kind;
            slot_sent[i]    = item.current_time;
            slot_retries[i] = '0;
            res.slot_used   = SLOT_W'(i);
            done            = 1;
          end
        end
        if (!done) begin
          res.status = ST_NO_FREE;
        end
      end
      OP_REMOVE: begin
        // Only the key is compared; the kind does not matter here.
        for (int i = 0; i < SLOTS && !done; i++) begin
          if (slot_valid[i] && slot_key[i] == item.message_key) begin
            slot_valid[i] = 1'b0;
            res.slot_used = SLOT_W'(i);
            done          = 1;
          end
        end
        if (!done) begin
          res.status = ST_NOT_FOUND;
        end
      end
      OP_CHECK: begin
        // In-order scan; the first entry to reach the retry limit ends it.
        for (int i = 0; i < SLOTS; i++) begin
          if (!slot_valid[i]) begin
            continue;
          end
          elapsed = item.current_time - slot_sent[i];
          if (elapsed < TIME_W'(timeout_reg)) begin
            continue;
          end
          if (slot_retries[i] < RETRY_MAX) begin
            slot_retries[i] = slot_retries[i] + 1'b1;
          end
          if (slot_retries[i] >= retry_reg) begin
            link_lost             = 1'b1;
            res.disconnect        = 1'b1;
            res.retransmit_needed = 1'b0;
            break;
          end
          slot_sent[i]          = item.current_time;
          res.retransmit_needed = 1'b1;
        end
      end
      default: begin
        // The spare operation code leaves everything alone.
      end
    endcase
    res.timeout_latched = link_lost;
    return res;
  endfunction

  // Results are compared before new items are predicted, since an item
  // cannot leave at the edge where it is taken.
  always @(posedge clk) begin
    art_out_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_valid[i] = 1'b0;
      end
      link_lost    = 1'b0;
      timeout_reg  = TIMEOUT_RST;
      retry_reg    = RETRY_RST;
      mismatches   = 0;
      result_count = 0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no item pending, count", 0, 1);
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status) begin
            report_mismatch("status", want.status, out_data.status);
          end
          if (out_data.slot_used !== want.slot_used) begin
            report_mismatch("slot_used", want.slot_used, out_data.slot_used);
          end
          if (out_data.retransmit_needed !== want.retransmit_needed) begin
            report_mismatch("retransmit_needed", want.retransmit_needed,
                            out_data.retransmit_needed);
          end
          if (out_data.disconnect !== want.disconnect) begin
            report_mismatch("disconnect", want.disconnect, out_data.disconnect);
          end
          if (out_data.timeout_latched !== want.timeout_latched) begin
            report_mismatch("timeout_latched", want.timeout_latched,
                            out_data.timeout_latched);
          end
        end
        result_count++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TIMEOUT: timeout_reg = cfg_wdata[TMO_W-1:0];
          CFG_RETRY:   retry_reg   = cfg_wdata[RETRY_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_tracker_step(in_data));
      end
    end
    pending = expected_results.size();
  end

endmodule

### tb/tb.sv
// Top of the tracker testbench: clock, reset, stimulus, flow control and the verdict.
// Instantiates ack_retransmit_tracker and art_tracker_checker; depends on art_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import art_pkg::*;

  localparam int          SLOTS        = SLOTS_DEF;
  localparam logic [1:0]  OP_NONE      = 2'd3;
  localparam int          KEY_POOL     = 10;
  localparam int          PHASES       = 6;
  localparam int          PHASE_ITEMS  = 335;
  localparam int          SETTLE       = SLOTS + 6;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          CYCLE_LIMIT  = 600000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  art_in_t    in_data;
  logic       out_valid;
  logic       out_stall;
  art_out_t   out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int mismatches;
  int pending;
  int cycles;

  // Flow-control requests from the stimulus to the receiver.
  bit calm;
  bit hold_req;

  logic [KEY_W-1:0]  key_pool  [KEY_POOL];
  logic [KIND_W-1:0] kind_pool [3];
  logic [TIME_W-1:0] clock_now;
  int                time_span;

  ack_retransmit_tracker #(.SLOTS(SLOTS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  art_tracker_checker #(.SLOTS(SLOTS)) chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: random stalls, a calm stretch, and one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 23);
      end
    end
  end

  // Offers one item, with an occasional gap first; starts and ends just after a falling edge.
  task automatic put_item(input art_in_t item);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic make_and_put(input logic [1:0] op, input logic [KEY_W-1:0] key,
                              input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] now);
    art_in_t item;
    item.operation    = op;
    item.message_key  = key;
    item.message_kind = kind;
    item.current_time = now;
    put_item(item);
  endtask

  // Stops offering and waits until every result is back and the block has settled.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly known keys and kinds so that refreshes and removes hit; time mostly
  // creeps forward on the scale of the timeout, with rare jumps anywhere.
  function automatic art_in_t random_item();
    art_in_t item;
    int      pick;
    pick = $urandom_range(99);
    if (pick < 35) begin
      item.operation = OP_ADD;
    end else if (pick < 60) begin
      item.operation = OP_REMOVE;
    end else if (pick < 95) begin
      item.operation = OP_CHECK;
    end else begin
      item.operation = OP_NONE;
    end
    if ($urandom_range(99) < 75) begin
      item.message_key = key_pool[$urandom_range(KEY_POOL - 1)];
    end else begin
      item.message_key = $urandom();
    end
    if ($urandom_range(99) < 80) begin
      item.message_kind = kind_pool[$urandom_range(2)];
    end else begin
      item.message_kind = KIND_W'($urandom());
    end
    if ($urandom_range(99) < 3) begin
      clock_now = $urandom();
    end else begin
      clock_now = clock_now + $urandom_range(time_span);
    end
    item.current_time = clock_now;
    return item;
  endfunction

  initial begin
    logic [TMO_W-1:0]   phase_timeout [PHASES];
    logic [RETRY_W-1:0] phase_retry   [PHASES];
    phase_timeout = '{16'd3, 16'd0, 16'd65535, 16'd1, 16'd12, 16'd200};
    phase_retry   = '{4'd2, 4'd0, 4'd15, 4'd1, 4'd5, 4'd7};

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    calm      = 0;
    hold_req  = 0;
    cycles    = 0;
    for (int i = 0; i < KEY_POOL; i++) begin
      key_pool[i] = $urandom();
    end
    for (int i = 0; i < 3; i++) begin
      kind_pool[i] = KIND_W'($urandom());
    end
    clock_now = '0;
    time_span = 7;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under the reset values of the registers.
    make_and_put(OP_REMOVE, 32'h0, 8'h0, 32'h0);                  // not found on empty table
    make_and_put(OP_CHECK, 32'h0, 8'h0, 32'h0);                   // nothing to scan
    make_and_put(OP_NONE, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);   // spare code ignored
    make_and_put(OP_ADD, 32'h0, 8'h0, 32'h0);
    make_and_put(OP_ADD, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFE);
    make_and_put(OP_ADD, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);    // refresh
    make_and_put(OP_ADD, 32'hFFFF_FFFF, 8'h00, 32'h0);            // same key, other kind
    for (int i = 0; i < 6; i++) begin
      make_and_put(OP_ADD, key_pool[i], kind_pool[i % 3], 32'h1); // last one finds no room
    end
    make_and_put(OP_REMOVE, 32'hFFFF_FFFF, 8'h12, 32'h0);         // first of two matches
    make_and_put(OP_ADD, 32'h0, 8'h0, 32'h2);                     // refresh slot zero
    make_and_put(OP_CHECK, 32'h0, 8'h0, 32'h4);                   // nothing due yet
    make_and_put(OP_CHECK, 32'h0, 8'h0, 32'h6);                   // some entries resent
    make_and_put(OP_CHECK, 32'h0, 8'h0, 32'd100);                 // all due
    make_and_put(OP_CHECK, 32'h0, 8'h0, 32'd200);                 // retry limit reached
    make_and_put(OP_NONE, 32'h0, 8'h0, 32'h0);                    // sticky flag shows
    make_and_put(OP_REMOVE, 32'h0001_2345, 8'h0, 32'h0);
    make_and_put(OP_CHECK, 32'h0, 8'h0, 32'h3);                   // elapsed wraps around
    make_and_put(OP_REMOVE, 32'h0, 8'h0, 32'h0);
    drain();

    // Random phases, each under its own register setting.
    for (int p = 0; p < PHASES; p++) begin
      write_reg(CFG_TIMEOUT, CFG_DATA_W'(phase_timeout[p]));
      write_reg(CFG_RETRY, CFG_DATA_W'(phase_retry[p]));
      time_span = int'(phase_timeout[p]) + 2;
      calm = (p == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 0 && n == 100) begin
          hold_req = 1;
        end
        put_item(random_item());
        if (p == 2 && n == 150) begin
          drain();
        end
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
